@@ rtl/core/kle_pkg.sv @@
// kle_pkg: shared constants, codes and types of the keypad line editor
// no dependencies
package kle_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

	localparam logic [1:0] REG_ENTER  = 2'd0;
	localparam logic [1:0] REG_DELETE = 2'd1;

	localparam logic [7:0] ENTER_RESET  = 8'd10;
	localparam logic [7:0] DELETE_RESET = 8'd8;

	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NONE      = 8'h00;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_READ = 2'd1,
		KIND_EOL  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		JOB_ECHO   = 2'd0,
		JOB_DELETE = 2'd1,
		JOB_READ   = 2'd2,
		JOB_EOL    = 2'd3
	} job_code_t;

	typedef struct packed {
		job_code_t  code;
		logic [7:0] ch;
	} job_t;

endpackage

@@ rtl/core/kle_out_seq.sv @@
// kle_out_seq: output register and result sequencer, one job to one or three results
// depends on kle_pkg
module kle_out_seq import kle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_ready,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] character,
	output logic       last
);

	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       last_q;
	logic [1:0] rem_q;
	logic       take;

	assign take      = valid_q && !out_stall;
	assign job_ready = (!valid_q || take) && (rem_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 2'd0;
			kind_q  <= KIND_ECHO;
			char_q  <= CH_NONE;
			last_q  <= 1'b0;
		end else if (job_valid && job_ready) begin
			valid_q <= 1'b1;
			unique case (job.code)
				JOB_ECHO: begin
					kind_q <= KIND_ECHO;
					char_q <= job.ch;
					last_q <= 1'b1;
					rem_q  <= 2'd0;
				end
				JOB_DELETE: begin
					kind_q <= KIND_ECHO;
					char_q <= CH_BACKSPACE;
					last_q <= 1'b0;
					rem_q  <= 2'd2;
				end
				JOB_READ: begin
					kind_q <= KIND_READ;
					char_q <= job.ch;
					last_q <= 1'b1;
					rem_q  <= 2'd0;
				end
				JOB_EOL: begin
					kind_q <= KIND_EOL;
					char_q <= CH_NONE;
					last_q <= 1'b1;
					rem_q  <= 2'd0;
				end
				default: begin
					kind_q <= KIND_EOL;
					char_q <= CH_NONE;
					last_q <= 1'b1;
					rem_q  <= 2'd0;
				end
			endcase
		end else if (take) begin
			if (rem_q != 2'd0) begin
				char_q <= (rem_q == 2'd2) ? CH_SPACE : CH_BACKSPACE;
				last_q <= (rem_q == 2'd1);
				rem_q  <= rem_q - 2'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

@@ rtl/core/keypad_line_editor_unit.sv @@
// Keypad line editor: collects key codes into a line store and replays them on read requests.
// Takes the line RAM, the control state and the decode stage; depends on kle_pkg, kle_out_seq.
// Throughput: a transaction is accepted every cycle as long as the output side keeps up; its
// results pass through the decode stage register (with the synchronous line RAM read) and then the
// output register. A delete key gives three echo results and holds the output register until all
// three are taken, stalling the transactions behind it. Key presses and read requests that give
// no result leave no trace in the pipeline. The line RAM needs no clearing after reset; entries
// are read only below the current character count. Configuration is written through
// cfg_we/cfg_index/cfg_data.
module keypad_line_editor_unit import kle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] key_code,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] character,
	output logic       last
);

	logic [7:0]       mem [LINE_DEPTH];
	logic [7:0]       rdata_q;
	logic [7:0]       enter_q;
	logic [7:0]       delete_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             replay_q;

	logic             s1_valid_s1;
	job_code_t        code_s1;
	logic [7:0]       key_s1;

	logic             in_fire;
	logic             gen;
	job_code_t        gen_code;
	logic             mem_we;
	logic             mem_re;
	logic             job_ready;
	job_t             job;

	assign in_fire = in_valid && !in_stall;
	assign in_stall = s1_valid_s1 && !job_ready;

	// decode of the incoming transaction
	always_comb begin
		gen      = 1'b0;
		gen_code = JOB_ECHO;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		if (operation == OP_KEY) begin
			if (!replay_q && key_code != enter_q) begin
				if (key_code == delete_q) begin
					gen      = (cnt_q != '0);
					gen_code = JOB_DELETE;
				end else if (cnt_q != DEPTH_CNT) begin
					gen      = 1'b1;
					gen_code = JOB_ECHO;
					mem_we   = in_fire;
				end
			end
		end else if (replay_q) begin
			gen = 1'b1;
			if (rd_idx_q < cnt_q) begin
				gen_code = JOB_READ;
				mem_re   = in_fire;
			end else begin
				gen_code = JOB_EOL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[ADDR_W-1:0]] <= key_code;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q  <= ENTER_RESET;
			delete_q <= DELETE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENTER) begin
				enter_q <= cfg_data;
			end else if (cfg_index == REG_DELETE) begin
				delete_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_idx_q <= '0;
			replay_q <= 1'b0;
		end else if (in_fire) begin
			if (operation == OP_KEY) begin
				if (!replay_q) begin
					if (key_code == enter_q) begin
						replay_q <= 1'b1;
						rd_idx_q <= '0;
					end else if (key_code == delete_q) begin
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end else if (cnt_q != DEPTH_CNT) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
			end else if (replay_q) begin
				if (rd_idx_q < cnt_q) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end else begin
					cnt_q    <= '0;
					rd_idx_q <= '0;
					replay_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= gen;
		end else if (job_ready) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && gen) begin
			code_s1 <= gen_code;
			key_s1  <= key_code;
		end
	end

	assign job.code = code_s1;
	assign job.ch   = (code_s1 == JOB_READ) ? rdata_q : key_s1;

	kle_out_seq u_out_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (s1_valid_s1),
		.job       (job),
		.job_ready (job_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.character (character),
		.last      (last)
	);

endmodule

@@ verif/keypad_line_editor_unit_test.sv @@
// keypad_line_editor_unit_test: self-checking testbench of the keypad line editor
// predicts echo, read and end-of-line results per transaction and checks them in order
// depends on kle_pkg and keypad_line_editor_unit
module keypad_line_editor_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import kle_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD     = 200;
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} editor_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       operation;
	logic [7:0] key_code;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] character;
	logic       last;

	editor_out_t editor_outputs_due[$];

	logic [7:0]       line_copy [LINE_DEPTH];
	logic [CNT_W-1:0] held_count;
	logic [CNT_W-1:0] replay_pos;
	logic             in_replay;
	logic [7:0]       enter_key;
	logic [7:0]       delete_key;

	int acted_items;
	int fail_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;

	keypad_line_editor_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.key_code  (key_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.character (character),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		editor_out_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (editor_outputs_due.size() == 0) begin
				$error("unexpected transaction: kind %0d character %0h last %0b",
					kind, character, last);
				fail_count++;
			end else begin
				due = editor_outputs_due.pop_front();
				if (kind !== due.kind) begin
					$error("kind: expected %0d, actual %0d", due.kind, kind);
					fail_count++;
				end
				if (character !== due.ch) begin
					$error("character: expected %0h, actual %0h", due.ch, character);
					fail_count++;
				end
				if (last !== due.last) begin
					$error("last: expected %0b, actual %0b", due.last, last);
					fail_count++;
				end
			end
		end
	end

	function automatic void expect_out(kind_t k, logic [7:0] c, logic l);
		editor_outputs_due.push_back('{k, c, l});
	endfunction

	task automatic predict_editor(input logic op, input logic [7:0] key);
		if (op == OP_KEY) begin
			if (!in_replay) begin
				if (key == enter_key) begin
					in_replay = 1'b1;
					replay_pos = '0;
					acted_items++;
				end else if (key == delete_key) begin
					if (held_count != 0) begin
						held_count--;
						expect_out(KIND_ECHO, CH_BACKSPACE, 1'b0);
						expect_out(KIND_ECHO, CH_SPACE, 1'b0);
						expect_out(KIND_ECHO, CH_BACKSPACE, 1'b1);
						acted_items++;
					end
				end else if (held_count < DEPTH_CNT) begin
					line_copy[held_count[ADDR_W-1:0]] = key;
					held_count++;
					expect_out(KIND_ECHO, key, 1'b1);
					acted_items++;
				end
			end
		end else if (in_replay) begin
			acted_items++;
			if (replay_pos < held_count) begin
				expect_out(KIND_READ, line_copy[replay_pos[ADDR_W-1:0]], 1'b1);
				replay_pos++;
			end else begin
				expect_out(KIND_EOL, CH_NONE, 1'b1);
				held_count = '0;
				replay_pos = '0;
				in_replay = 1'b0;
			end
		end
	endtask

	task automatic send_item(input logic op, input logic [7:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		key_code <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_editor(op, key);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENTER: enter_key = value;
			REG_DELETE: delete_key = value;
			default: ;
		endcase
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (editor_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rates(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic run_random_line();
		int len;
		int pick;
		logic [7:0] k;
		if ($urandom_range(99) < 85) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
			repeat (len) begin
				pick = $urandom_range(99);
				if (pick < 15)
					send_item(OP_KEY, delete_key);
				else if (pick < 20)
					send_item(OP_READ, 8'($urandom));
				else
					send_item(OP_KEY, 8'($urandom));
			end
			send_item(OP_KEY, enter_key);
			while (in_replay) begin
				if ($urandom_range(9) == 0)
					send_item(OP_KEY, 8'($urandom));
				else
					send_item(OP_READ, 8'($urandom));
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(3);
				k = (pick == 0) ? enter_key : (pick == 1) ? delete_key : 8'($urandom);
				send_item(1'($urandom_range(1)), k);
			end
		end
	endtask

	task automatic test_directed_basics();
		set_rates(0, 0);
		write_reg(REG_SPARE_LO, 8'h00);
		write_reg(REG_SPARE_HI, 8'hFF);
		write_reg(REG_ENTER, ENTER_RESET);
		write_reg(REG_DELETE, DELETE_RESET);
		send_item(OP_READ, 8'hFF);
		send_item(OP_KEY, delete_key);
		send_item(OP_KEY, 8'h00);
		send_item(OP_KEY, 8'hFF);
		send_item(OP_KEY, 8'h55);
		send_item(OP_KEY, delete_key);
		send_item(OP_READ, 8'h00);
		send_item(OP_KEY, enter_key);
		send_item(OP_KEY, 8'h41);
		send_item(OP_KEY, enter_key);
		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'hFF);
		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'h00);
		send_item(OP_KEY, enter_key);
		send_item(OP_READ, 8'h00);
		send_item(OP_KEY, 8'hAA);
		send_item(OP_KEY, delete_key);
		send_item(OP_KEY, delete_key);
		send_item(OP_KEY, enter_key);
		send_item(OP_READ, 8'h00);
	endtask

	task automatic test_enter_equals_delete();
		wait_for_results();
		write_reg(REG_ENTER, 8'h7F);
		write_reg(REG_DELETE, 8'h7F);
		send_item(OP_KEY, 8'h01);
		send_item(OP_KEY, DELETE_RESET);
		send_item(OP_KEY, 8'h7F);
		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'h00);
		send_item(OP_READ, 8'h00);
	endtask

	task automatic test_full_line();
		wait_for_results();
		write_reg(REG_ENTER, 8'h00);
		write_reg(REG_DELETE, 8'hFF);
		@(posedge clk);
		set_rates(22, 22);
		repeat (LINE_DEPTH + 3) send_item(OP_KEY, 8'($urandom_range(1, 254)));
		send_item(OP_KEY, delete_key);
		send_item(OP_KEY, 8'($urandom_range(1, 254)));
		send_item(OP_KEY, 8'($urandom_range(1, 254)));
		send_item(OP_KEY, enter_key);
		while (in_replay)
			send_item(OP_READ, 8'($urandom));
	endtask

	task automatic test_backpressure();
		wait_for_results();
		@(posedge clk);
		set_rates(0, 0);
		hold_request = LONG_HOLD;
		repeat (20) begin
			if ($urandom_range(4) == 0)
				send_item(OP_KEY, delete_key);
			else
				send_item(OP_KEY, 8'($urandom_range(1, 254)));
		end
		send_item(OP_KEY, enter_key);
		while (in_replay)
			send_item(OP_READ, 8'($urandom));
	endtask

	task automatic test_random_lines(input int send_pct, input int stall_pct,
		input logic [7:0] enter_v, input logic [7:0] delete_v, input int target);
		wait_for_results();
		write_reg(REG_ENTER, enter_v);
		write_reg(REG_DELETE, delete_v);
		@(posedge clk);
		set_rates(send_pct, stall_pct);
		acted_items = 0;
		while (acted_items < target)
			run_random_line();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_KEY;
		key_code = '0;
		held_count = '0;
		replay_pos = '0;
		in_replay = 1'b0;
		enter_key = ENTER_RESET;
		delete_key = DELETE_RESET;
		fail_count = 0;
		cycle_count = 0;
		hold_request = 0;
		set_rates(0, 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_basics();
		test_enter_equals_delete();
		test_full_line();
		test_backpressure();
		test_random_lines(0, 0, ENTER_RESET, DELETE_RESET, 12);
		test_random_lines(84, 0, 8'hFF, 8'h00, 12);
		test_random_lines(0, 84, 8'h30, 8'h31, 12);
		test_random_lines(22, 22, 8'($urandom), 8'($urandom), 12);
		wait_for_results();

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/kle_pkg.sv
rtl/core/kle_out_seq.sv
rtl/core/keypad_line_editor_unit.sv
verif/keypad_line_editor_unit_test.sv
